FILE: design/sorted_array_priority_queue_top_assert.svh
// Assertion macros used by the sorted-array priority queue top level.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define SPAQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds while reset is asserted.
`define SPAQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPAQ_ASSERT(label, prop, msg)
`define SPAQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: design/spaq_pkg.sv
// Types and constants shared by the sorted-array priority queue.
package spaq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int COUNT_OUT_W      = 5;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed
    {
        cmd_t                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } in_t;

    typedef struct packed
    {
        status_t                    status;
        logic signed [VALUE_W-1:0]  removed_value;
        logic signed [VALUE_W-1:0]  head_value;
        logic                       head_valid;
        logic [COUNT_OUT_W-1:0]     entry_count;
    } out_t;

    // Broadcast to every cell of the chain in the cycle a transaction is taken.
    typedef struct packed
    {
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctrl_t;

endpackage

FILE: design/spaq_cell.sv
// One storage cell of the sorted chain: holds a value and shifts with its neighbours.
module spaq_cell
(
    input  logic                                 clk,
    input  spaq_pkg::cell_ctrl_t                 ctrl,
    input  logic                                 occ,
    input  logic                                 left_lt,
    input  logic signed [spaq_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [spaq_pkg::VALUE_W-1:0]  right_value,
    output logic                                 lt,
    output logic signed [spaq_pkg::VALUE_W-1:0]  value
);

    logic signed [spaq_pkg::VALUE_W-1:0] value_reg;
    logic signed [spaq_pkg::VALUE_W-1:0] value_next;

    // A held entry smaller than the new value stays where it is.
    assign lt    = occ && (value_reg < ctrl.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (lt)
            begin
                value_next = value_reg;
            end
            else if (left_lt)
            begin
                value_next = ctrl.value;
            end
            else
            begin
                value_next = left_value;
            end
        end
        else if (ctrl.rem)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: design/sorted_array_priority_queue_top.sv
// Top level of the sorted-array min priority queue built as a chain of cells.
//
//  Channel | Handshake            | Payload          | Role
//  --------+----------------------+------------------+------------------------------
//  request | req_valid, req_ready | req  (in_t)      | insert a value or remove head
//  result  | rsp_valid, rsp_ready | rsp  (out_t)     | status, removed value, head
//
// One transaction is taken per clock cycle unless a result is stalled; its result
// appears in the next cycle from the result register, and a new request is taken in
// the same cycle that result is; the rate is set by the cell chain and that register.
// Reset clears the entry count and the result valid flag; the cells and the result
// fields need no clearing.
// While a result waits with rsp_ready low, req_ready is low and the chain holds.
`include "sorted_array_priority_queue_top_assert.svh"

module sorted_array_priority_queue_top
#(
    parameter int CAPACITY = spaq_pkg::DEFAULT_CAPACITY
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  spaq_pkg::in_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output spaq_pkg::out_t  rsp
);

    // The count register holds 0 .. CAPACITY inclusive.
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;

    spaq_pkg::status_t                   status_reg;
    spaq_pkg::status_t                   status_next;
    logic signed [spaq_pkg::VALUE_W-1:0] removed_reg;
    logic signed [spaq_pkg::VALUE_W-1:0] removed_next;

    spaq_pkg::cell_ctrl_t                ctrl;
    logic                                accept;
    logic                                full;
    logic                                empty;
    logic [CW+spaq_pkg::COUNT_OUT_W-1:0] count_wide;

    logic signed [spaq_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic                                cell_lt    [CAPACITY];
    logic                                cell_occ   [CAPACITY];

    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);

    // A waiting result blocks the request side, so the chain and count stay put.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // Only a legal operation moves the chain: a full insert or an empty remove
    // leaves every cell untouched.
    always_comb
    begin
        ctrl.ins   = accept && (req.cmd == spaq_pkg::CMD_INSERT) && !full;
        ctrl.rem   = accept && (req.cmd == spaq_pkg::CMD_REMOVE) && !empty;
        ctrl.value = req.value;
    end

    // The chain: cell 0 holds the smallest entry. On insert the comparison results
    // form a prefix, so each cell need look only at its left neighbour to decide
    // whether to keep, take the new value, or take the neighbour's value. On remove
    // every cell takes its right neighbour's value.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                                left_lt;
        logic signed [spaq_pkg::VALUE_W-1:0] left_value;
        logic signed [spaq_pkg::VALUE_W-1:0] right_value;

        assign cell_occ[i] = (count_reg > CW'(i));

        if (i == 0)
        begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = req.value;
        end
        else
        begin : g_inner
            assign left_lt    = cell_lt[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_body
            assign right_value = cell_value[i+1];
        end

        spaq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .occ         (cell_occ[i]),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .lt          (cell_lt[i]),
            .value       (cell_value[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = spaq_pkg::STATUS_OK;
            removed_next   = '0;
            if (req.cmd == spaq_pkg::CMD_INSERT)
            begin
                if (full)
                begin
                    status_next = spaq_pkg::STATUS_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = spaq_pkg::STATUS_UNDERFLOW;
                end
                else
                begin
                    removed_next = cell_value[0];
                    count_next   = count_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // The head fields are read live from cell 0 and the count; both are frozen
    // while the result waits, so the result stays steady.
    assign count_wide = {{spaq_pkg::COUNT_OUT_W{1'b0}}, count_reg};

    assign rsp_valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = removed_reg;
    assign rsp.head_value    = empty ? '0 : cell_value[0];
    assign rsp.head_valid    = !empty;
    assign rsp.entry_count   = count_wide[spaq_pkg::COUNT_OUT_W-1:0];

    `SPAQ_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "entry count beyond capacity")
    `SPAQ_ASSERT_ALWAYS(a_stall_blocks, (rsp_valid_reg && !rsp_ready) |-> !req_ready, "stall")
    `SPAQ_ASSERT(a_insert_count, ctrl.ins |=> (count_reg == $past(count_reg) + CW'(1)), "insert")
    `SPAQ_ASSERT(a_underflow_empty, (rsp_valid_reg && status_reg == spaq_pkg::STATUS_UNDERFLOW) |-> empty, "underflow")
    `SPAQ_ASSERT(a_head_order, (count_reg >= CW'(2)) |-> (cell_value[0] <= cell_value[1]), "head order")

endmodule
